// ===== rtl/dmph_pkg.sv =====
// Shared constants, types and state codes of the dual M61 hash fold block.
package dmph_pkg;

   localparam int ResWidth  = 61;
   localparam int WordWidth = 64;
   localparam int ByteWidth = 8;
   localparam int CsrIndexWidth = 2;

   // Mersenne prime 2^61 - 1 and its double, widened to a full word
   localparam logic [WordWidth-1:0] M61     = 64'h1FFF_FFFF_FFFF_FFFF;
   localparam logic [WordWidth-1:0] M61_X2  = 64'h3FFF_FFFF_FFFF_FFFE;

   // Finalizer offsets and multipliers
   localparam logic [WordWidth-1:0] OFFSET_FIRST  = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [WordWidth-1:0] OFFSET_SECOND = 64'h3c6e_f372_fe94_f82a;
   localparam logic [WordWidth-1:0] MIX_MUL_ONE   = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [WordWidth-1:0] MIX_MUL_TWO   = 64'h94d0_49bb_1331_11eb;

   localparam logic [ResWidth-1:0] BASE_A_RESET = 61'd257;
   localparam logic [ResWidth-1:0] BASE_B_RESET = 61'd258;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BASE_A = 2'd0,
      CSR_BASE_B = 2'd1,
      CSR_PAD_A  = 2'd2,
      CSR_PAD_B  = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MM0,
      ST_MM1,
      ST_MM2,
      ST_MM3,
      ST_MM4,
      ST_MIX_PRE,
      ST_MIX0,
      ST_MIX1,
      ST_MIX2,
      ST_SUM,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/dmph_if.sv =====
// Request and response channel interfaces of the dual M61 hash fold block.
interface dmph_req_if;
   logic                             valid;
   logic                             ready;
   logic [dmph_pkg::ByteWidth-1:0]   data_byte;
   logic                             last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface dmph_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [dmph_pkg::WordWidth-1:0]   folded_hash;
   logic [dmph_pkg::ResWidth-1:0]    residue_first;
   logic [dmph_pkg::ResWidth-1:0]    residue_second;

   modport source (output valid, output folded_hash, output residue_first,
                   output residue_second, input ready);
   modport sink   (input valid, input folded_hash, input residue_first,
                   input residue_second, output ready);
endinterface

// ===== rtl/dual_m61_polynomial_hash_fold.sv =====
// Dual polynomial hash modulo 2^61-1 with splitmix64 fold, on one shared multiplier.
// A request is accepted only in idle; the block then runs the M61 step for both residues,
//   and a request with last also runs the finalizer of each lane and the fold into a
// registered response, waiting in ST_OUT while the response register is still full.
// The single 32x32 multiplier forms 8 partial products per byte and 12 more to fold.
// Reset (synchronous, active high) clears both residues, the sequencer and the response
//   valid, and loads base_a = 257, base_b = 258, pad_a = pad_b = 0.
module dual_m61_polynomial_hash_fold (
   input  logic                                    clock,
   input  logic                                    reset,
   dmph_req_if.sink                                req_chan,
   dmph_rsp_if.source                              rsp_chan,
   input  logic                                    csr_write_enable,
   input  logic [dmph_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [dmph_pkg::WordWidth-1:0]          csr_write_data
);

   localparam int RW = dmph_pkg::ResWidth;
   localparam int WW = dmph_pkg::WordWidth;
   localparam int BW = dmph_pkg::ByteWidth;

   // Configuration registers
   logic [RW-1:0] base_a_ff;
   logic [RW-1:0] base_b_ff;
   logic [WW-1:0] pad_a_ff;
   logic [WW-1:0] pad_b_ff;

   // Sequencer
   dmph_pkg::state_type state_ff, state_in;
   logic                lane_ff, lane_in;     // 0: first residue, 1: second residue
   logic                round_ff, round_in;   // finalizer multiply round

   // Running residues
   logic [RW-1:0] acc_first_ff, acc_first_in;
   logic [RW-1:0] acc_second_ff, acc_second_in;

   // Latched request
   logic [BW-1:0] byte_ff, byte_in;
   logic          last_ff, last_in;

   // Datapath work registers
   logic [WW-1:0] work_ff, work_in;
   logic [31:0]   hi_ff, hi_in;
   logic [WW-1:0] x_ff, x_in;
   logic [WW-1:0] h1_ff, h1_in;

   // Response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0] rsp_hash_ff, rsp_hash_in;
   logic [RW-1:0] rsp_res_a_ff, rsp_res_a_in;
   logic [RW-1:0] rsp_res_b_ff, rsp_res_b_in;

   // Shared multiplier
   logic [31:0]   mul_op_a;
   logic [31:0]   mul_op_b;
   logic [WW-1:0] mul_prod;

   // Lane selection
   logic [RW-1:0] res_cur;
   logic [RW-1:0] base_cur;
   logic [WW-1:0] pad_cur;
   logic [WW-1:0] offset_cur;
   logic [WW-1:0] mix_mul_cur;

   // Intermediate values
   logic [WW-1:0] red_word;
   logic [RW:0]   add_sum;
   logic [RW-1:0] new_res;
   logic [WW-1:0] pre_sum;
   logic [WW-1:0] prod_sum;
   logic [WW-1:0] mixed;
   logic          out_free;

   assign res_cur     = lane_ff ? acc_second_ff : acc_first_ff;
   assign base_cur    = lane_ff ? base_b_ff : base_a_ff;
   assign pad_cur     = lane_ff ? pad_b_ff : pad_a_ff;
   assign offset_cur  = lane_ff ? dmph_pkg::OFFSET_SECOND : dmph_pkg::OFFSET_FIRST;
   assign mix_mul_cur = round_ff ? dmph_pkg::MIX_MUL_TWO : dmph_pkg::MIX_MUL_ONE;

   // Steer the multiplier: four cross products for the M61 step, three for the 64-bit low product
   always_comb begin
      mul_op_a = '0;
      mul_op_b = '0;
      unique case (state_ff)
         dmph_pkg::ST_MM0: begin
            mul_op_a = {3'b000, res_cur[RW-1:32]};
            mul_op_b = base_cur[31:0];
         end
         dmph_pkg::ST_MM1: begin
            mul_op_a = res_cur[31:0];
            mul_op_b = {3'b000, base_cur[RW-1:32]};
         end
         dmph_pkg::ST_MM2: begin
            mul_op_a = {3'b000, res_cur[RW-1:32]};
            mul_op_b = {3'b000, base_cur[RW-1:32]};
         end
         dmph_pkg::ST_MM3: begin
            mul_op_a = res_cur[31:0];
            mul_op_b = base_cur[31:0];
         end
         dmph_pkg::ST_MIX0: begin
            mul_op_a = x_ff[31:0];
            mul_op_b = mix_mul_cur[31:0];
         end
         dmph_pkg::ST_MIX1: begin
            mul_op_a = x_ff[63:32];
            mul_op_b = mix_mul_cur[31:0];
         end
         dmph_pkg::ST_MIX2: begin
            mul_op_a = x_ff[31:0];
            mul_op_b = mix_mul_cur[63:32];
         end
         default: begin
            mul_op_a = '0;
            mul_op_b = '0;
         end
      endcase
   end

   assign mul_prod = {32'd0, mul_op_a} * {32'd0, mul_op_b};

   // Final reduction of the folded sum (below 2^62 + 2), then add byte + 1 and reduce again
   always_comb begin
      if (work_ff >= dmph_pkg::M61_X2) begin
         red_word = work_ff - dmph_pkg::M61_X2;
      end else if (work_ff >= dmph_pkg::M61) begin
         red_word = work_ff - dmph_pkg::M61;
      end else begin
         red_word = work_ff;
      end
      add_sum = {1'b0, red_word[RW-1:0]} + {{(RW+1-BW){1'b0}}, byte_ff} + {{RW{1'b0}}, 1'b1};
      if (add_sum >= dmph_pkg::M61[RW:0]) begin
         new_res = RW'(add_sum - dmph_pkg::M61[RW:0]);
      end else begin
         new_res = add_sum[RW-1:0];
      end
   end

   // Finalizer pieces: pad, offset and first shift-xor; low 64-bit product and its shift-xor
   assign pre_sum  = ({3'b000, res_cur} ^ pad_cur) + offset_cur;
   assign prod_sum = work_ff + {hi_ff + mul_prod[31:0], 32'd0};
   assign mixed    = round_ff ? (prod_sum ^ (prod_sum >> 31)) : (prod_sum ^ (prod_sum >> 27));

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      lane_in       = lane_ff;
      round_in      = round_ff;
      acc_first_in  = acc_first_ff;
      acc_second_in = acc_second_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      work_in       = work_ff;
      hi_in         = hi_ff;
      x_in          = x_ff;
      h1_in         = h1_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_hash_in   = rsp_hash_ff;
      rsp_res_a_in  = rsp_res_a_ff;
      rsp_res_b_in  = rsp_res_b_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         dmph_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               byte_in  = req_chan.data_byte;
               last_in  = req_chan.last;
               lane_in  = 1'b0;
               state_in = dmph_pkg::ST_MM0;
            end
         end
         dmph_pkg::ST_MM0: begin
            work_in  = mul_prod;
            state_in = dmph_pkg::ST_MM1;
         end
         dmph_pkg::ST_MM1: begin
            // middle cross sum
            work_in  = work_ff + mul_prod;
            state_in = dmph_pkg::ST_MM2;
         end
         dmph_pkg::ST_MM2: begin
            // fold the middle term at bit 29 and add the high product times 8
            work_in  = {3'b000, work_ff[28:0], 32'd0} + {29'd0, work_ff[63:29]}
                     + {mul_prod[RW-1:0], 3'b000};
            state_in = dmph_pkg::ST_MM3;
         end
         dmph_pkg::ST_MM3: begin
            work_in  = {61'd0, work_ff[63:61]} + {3'b000, work_ff[RW-1:0]}
                     + {61'd0, mul_prod[63:61]} + {3'b000, mul_prod[RW-1:0]};
            state_in = dmph_pkg::ST_MM4;
         end
         dmph_pkg::ST_MM4: begin
            if (lane_ff) begin
               acc_second_in = new_res;
               lane_in       = 1'b0;
               state_in      = last_ff ? dmph_pkg::ST_MIX_PRE : dmph_pkg::ST_IDLE;
            end else begin
               acc_first_in = new_res;
               lane_in      = 1'b1;
               state_in     = dmph_pkg::ST_MM0;
            end
         end
         dmph_pkg::ST_MIX_PRE: begin
            x_in     = pre_sum ^ (pre_sum >> 30);
            round_in = 1'b0;
            state_in = dmph_pkg::ST_MIX0;
         end
         dmph_pkg::ST_MIX0: begin
            work_in  = mul_prod;
            state_in = dmph_pkg::ST_MIX1;
         end
         dmph_pkg::ST_MIX1: begin
            hi_in    = mul_prod[31:0];
            state_in = dmph_pkg::ST_MIX2;
         end
         dmph_pkg::ST_MIX2: begin
            if (!round_ff) begin
               x_in     = mixed;
               round_in = 1'b1;
               state_in = dmph_pkg::ST_MIX0;
            end else if (!lane_ff) begin
               h1_in    = mixed;
               lane_in  = 1'b1;
               state_in = dmph_pkg::ST_MIX_PRE;
            end else begin
               x_in     = mixed;
               lane_in  = 1'b0;
               state_in = dmph_pkg::ST_SUM;
            end
         end
         dmph_pkg::ST_SUM: begin
            work_in  = h1_ff + x_ff;
            state_in = dmph_pkg::ST_OUT;
         end
         dmph_pkg::ST_OUT: begin
            // hold until the response register is free, then rotate by 23 and add h1
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hash_in   = {work_ff[40:0], work_ff[63:41]} + h1_ff;
               rsp_res_a_in  = acc_first_ff;
               rsp_res_b_in  = acc_second_ff;
               acc_first_in  = '0;
               acc_second_in = '0;
               state_in      = dmph_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dmph_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dmph_pkg::ST_IDLE;
         lane_ff       <= 1'b0;
         round_ff      <= 1'b0;
         acc_first_ff  <= '0;
         acc_second_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lane_ff       <= lane_in;
         round_ff      <= round_in;
         acc_first_ff  <= acc_first_in;
         acc_second_ff <= acc_second_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      work_ff      <= work_in;
      hi_ff        <= hi_in;
      x_ff         <= x_in;
      h1_ff        <= h1_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_res_a_ff <= rsp_res_a_in;
      rsp_res_b_ff <= rsp_res_b_in;
   end

   // Configuration writes; bases keep their low 61 bits
   always_ff @(posedge clock) begin
      if (reset) begin
         base_a_ff <= dmph_pkg::BASE_A_RESET;
         base_b_ff <= dmph_pkg::BASE_B_RESET;
         pad_a_ff  <= '0;
         pad_b_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dmph_pkg::CSR_BASE_A: base_a_ff <= csr_write_data[RW-1:0];
            dmph_pkg::CSR_BASE_B: base_b_ff <= csr_write_data[RW-1:0];
            dmph_pkg::CSR_PAD_A:  pad_a_ff  <= csr_write_data;
            dmph_pkg::CSR_PAD_B:  pad_b_ff  <= csr_write_data;
            default: begin
               base_a_ff <= base_a_ff;
            end
         endcase
      end
   end

   assign req_chan.ready          = (state_ff == dmph_pkg::ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.folded_hash    = rsp_hash_ff;
   assign rsp_chan.residue_first  = rsp_res_a_ff;
   assign rsp_chan.residue_second = rsp_res_b_ff;

   // Residues stay fully reduced
   assert property (@(posedge clock) disable iff (reset)
      (acc_first_ff != dmph_pkg::M61[RW-1:0]) && (acc_second_ff != dmph_pkg::M61[RW-1:0]))
      else $error("residue not reduced below 2^61-1");

   // An accepted request starts the first residue step
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == dmph_pkg::ST_MM0) && !lane_ff)
      else $error("accepted request did not start the residue step");

   // Emitting a response loads the output register and clears both residues
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == dmph_pkg::ST_OUT && out_free) |=>
         rsp_valid_ff && (acc_first_ff == '0) && (acc_second_ff == '0))
      else $error("response emit did not clear the residues");

   // A pending response is never overwritten before it is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff && $stable(rsp_hash_ff))
      else $error("pending response lost");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the dual M61 polynomial hash fold block.
`timescale 1ns / 100ps

module tb;

   localparam int WordWidth     = dmph_pkg::WordWidth;
   localparam int ResWidth      = dmph_pkg::ResWidth;
   localparam int ByteWidth     = dmph_pkg::ByteWidth;
   localparam int CsrIndexWidth = dmph_pkg::CsrIndexWidth;

   localparam int ClockPeriod = 10;
   localparam int ResetCycles = 6;
   // A request without last keeps the block busy through both residue steps after acceptance;
   // allow a margin before touching the registers.
   localparam int SettleCycles = 16;
   localparam int EndCycles = 40;
   localparam int TimeoutNs = 5_000_000;

   typedef struct packed {
      logic [WordWidth-1:0] folded_hash;
      logic [ResWidth-1:0]  residue_first;
      logic [ResWidth-1:0]  residue_second;
   } hash_result_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [WordWidth-1:0]     csr_write_data;

   dmph_req_if req_bus ();
   dmph_rsp_if rsp_bus ();

   dual_m61_polynomial_hash_fold DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the block's registers and running residues
   logic [ResWidth-1:0]  shadow_base_a;
   logic [ResWidth-1:0]  shadow_base_b;
   logic [WordWidth-1:0] shadow_pad_a;
   logic [WordWidth-1:0] shadow_pad_b;
   logic [ResWidth-1:0]  shadow_res_first;
   logic [ResWidth-1:0]  shadow_res_second;

   // Hashes predicted for strings whose last byte was accepted, oldest first
   hash_result_type pending_hashes[$];

   int send_idle_pct;
   int rsp_stall_pct;
   int error_count;
   int requests_sent;
   int strings_sent;
   int hashes_checked;
   int settings_applied;

   // ------------------------------------------------------------------
   // Clock, and a hard stop in case the block hangs
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   initial begin
      #(TimeoutNs);
      $display("Timeout at %0t: %0d hashes still pending", $time, pending_hashes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Full product reduced modulo 2^61-1; a multiplier equal to the prime
   // therefore acts as zero.
   function automatic logic [ResWidth-1:0] mersenne_mul_mod(logic [ResWidth-1:0] a,
                                                            logic [ResWidth-1:0] b);
      logic [127:0] product;
      product = 128'(a) * 128'(b);
      return ResWidth'(product % 128'(dmph_pkg::M61));
   endfunction

   function automatic logic [ResWidth-1:0] residue_advance(logic [ResWidth-1:0] r,
                                                           logic [ResWidth-1:0] base,
                                                           logic [ByteWidth-1:0] value);
      logic [WordWidth-1:0] sum;
      sum = WordWidth'(mersenne_mul_mod(r, base)) + WordWidth'(value) + 64'd1;
      if (sum >= dmph_pkg::M61) begin
         sum = sum - dmph_pkg::M61;
      end
      return sum[ResWidth-1:0];
   endfunction

   function automatic logic [WordWidth-1:0] splitmix_finalize(logic [WordWidth-1:0] x);
      logic [WordWidth-1:0] z;
      z = (x ^ (x >> 30)) * dmph_pkg::MIX_MUL_ONE;
      z = (z ^ (z >> 27)) * dmph_pkg::MIX_MUL_TWO;
      return z ^ (z >> 31);
   endfunction

   function automatic logic [WordWidth-1:0] fold_residues(logic [WordWidth-1:0] x,
                                                          logic [WordWidth-1:0] y);
      logic [WordWidth-1:0] h1;
      logic [WordWidth-1:0] h2;
      logic [WordWidth-1:0] s;
      h1 = splitmix_finalize(x + dmph_pkg::OFFSET_FIRST);
      h2 = splitmix_finalize(y + dmph_pkg::OFFSET_SECOND);
      s = h1 + h2;
      return {s[40:0], s[63:41]} + h1;
   endfunction

   // Advance both residues by one accepted byte; on last, queue the hash
   // and clear the residues.
   task automatic absorb_byte(logic [ByteWidth-1:0] value, logic is_last);
      hash_result_type want;
      shadow_res_first  = residue_advance(shadow_res_first, shadow_base_a, value);
      shadow_res_second = residue_advance(shadow_res_second, shadow_base_b, value);
      requests_sent++;
      if (is_last) begin
         want.folded_hash    = fold_residues(WordWidth'(shadow_res_first) ^ shadow_pad_a,
                                             WordWidth'(shadow_res_second) ^ shadow_pad_b);
         want.residue_first  = shadow_res_first;
         want.residue_second = shadow_res_second;
         pending_hashes.insert(pending_hashes.size(), want);
         shadow_res_first  = '0;
         shadow_res_second = '0;
         strings_sent++;
      end
   endtask

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one request, idling first at random; hold valid high when the
   // next request follows directly.
   task automatic send_byte(logic [ByteWidth-1:0] value, logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      req_bus.last      <= is_last;
      do @(posedge clock); while (!req_bus.ready);
      absorb_byte(value, is_last);
   endtask

   // Drop valid, wait for every pending hash, then let the block settle so
   // that a trailing request without last has finished too.
   task automatic wait_until_quiet(int extra_cycles);
      req_bus.valid <= 1'b0;
      while (pending_hashes.size() != 0) begin
         @(posedge clock);
      end
      repeat (extra_cycles) @(posedge clock);
   endtask

   task automatic write_register(dmph_pkg::csr_index_type idx, logic [WordWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         dmph_pkg::CSR_BASE_A: begin
            shadow_base_a = value[ResWidth-1:0];
         end
         dmph_pkg::CSR_BASE_B: begin
            shadow_base_b = value[ResWidth-1:0];
         end
         dmph_pkg::CSR_PAD_A: begin
            shadow_pad_a = value;
         end
         dmph_pkg::CSR_PAD_B: begin
            shadow_pad_b = value;
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic [ByteWidth-1:0] random_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return ByteWidth'($urandom);
      endcase
   endfunction

   // Mix legal bases with the extremes and with words whose upper bits are
   // dropped by the register.
   function automatic logic [WordWidth-1:0] random_base();
      case ($urandom_range(7))
         0: return 64'd257;
         1: return dmph_pkg::M61 - 64'd1;
         2: return dmph_pkg::M61;
         3: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [WordWidth-1:0] random_pad();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Response side: stall at random, compare each hash with the oldest
   // prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      hash_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_hashes.size() == 0) begin
            error_count++;
            $display("%0t: hash expected none actual %h residues %h %h", $time,
                     rsp_bus.folded_hash, rsp_bus.residue_first, rsp_bus.residue_second);
         end else begin
            want = pending_hashes.pop_front();
            hashes_checked++;
            if (rsp_bus.folded_hash !== want.folded_hash) begin
               error_count++;
               $display("%0t: folded_hash expected %h actual %h", $time,
                        want.folded_hash, rsp_bus.folded_hash);
            end
            if (rsp_bus.residue_first !== want.residue_first) begin
               error_count++;
               $display("%0t: residue_first expected %h actual %h", $time,
                        want.residue_first, rsp_bus.residue_first);
            end
            if (rsp_bus.residue_second !== want.residue_second) begin
               error_count++;
               $display("%0t: residue_second expected %h actual %h", $time,
                        want.residue_second, rsp_bus.residue_second);
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values of the registers: shortest string, extreme bytes.
   task automatic test_reset_settings();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_until_quiet(SettleCycles);
   endtask

   // Bases at the prime (multiplier of zero), just below it, at the low end
   // and with dropped upper bits; pads at both extremes.
   task automatic test_register_extremes();
      write_register(dmph_pkg::CSR_BASE_A, '1);
      write_register(dmph_pkg::CSR_BASE_B, dmph_pkg::M61 - 64'd1);
      write_register(dmph_pkg::CSR_PAD_A, '1);
      write_register(dmph_pkg::CSR_PAD_B, 64'hAAAA_AAAA_5555_5555);
      settings_applied++;
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      wait_until_quiet(SettleCycles);
      write_register(dmph_pkg::CSR_BASE_A, 64'd257);
      write_register(dmph_pkg::CSR_BASE_B, 64'hE000_0000_0000_0000);
      write_register(dmph_pkg::CSR_PAD_A, '0);
      write_register(dmph_pkg::CSR_PAD_B, '1);
      settings_applied++;
      send_byte(8'h80, 1'b1);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h01, 1'b1);
      wait_until_quiet(SettleCycles);
   endtask

   // Registers rewritten in the middle of a string apply from the next byte.
   task automatic test_midstring_update();
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      wait_until_quiet(SettleCycles);
      write_register(dmph_pkg::CSR_BASE_A, 64'h0123_4567_89AB_CDEF);
      write_register(dmph_pkg::CSR_PAD_B, 64'hFEDC_BA98_7654_3210);
      settings_applied++;
      send_byte(8'h56, 1'b0);
      send_byte(8'h78, 1'b1);
      wait_until_quiet(SettleCycles);
   endtask

   task automatic apply_random_settings();
      write_register(dmph_pkg::CSR_BASE_A, random_base());
      write_register(dmph_pkg::CSR_BASE_B, random_base());
      write_register(dmph_pkg::CSR_PAD_A, random_pad());
      write_register(dmph_pkg::CSR_PAD_B, random_pad());
      settings_applied++;
   endtask

   // Random strings, mostly short with an occasional long one, under one
   // handshake profile.
   task automatic test_random_strings(int item_target, int idle_pct, int stall_pct);
      int sent;
      int length;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      apply_random_settings();
      while (sent < item_target) begin
         if ($urandom_range(9) == 0) begin
            length = $urandom_range(48, 9);
         end else begin
            length = $urandom_range(8, 1);
         end
         for (int k = 1; k <= length; k++) begin
            send_byte(random_byte(), k == length);
         end
         sent += length;
      end
      wait_until_quiet(SettleCycles);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      error_count      = 0;
      requests_sent    = 0;
      strings_sent     = 0;
      hashes_checked   = 0;
      settings_applied = 1;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      shadow_base_a     = dmph_pkg::BASE_A_RESET;
      shadow_base_b     = dmph_pkg::BASE_B_RESET;
      shadow_pad_a      = '0;
      shadow_pad_b      = '0;
      shadow_res_first  = '0;
      shadow_res_second = '0;

      // Hold every input at a known value through reset
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last      <= 1'b0;
      csr_write_enable  <= 1'b0;
      csr_index         <= dmph_pkg::CSR_BASE_A;
      csr_write_data    <= '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      repeat (SettleCycles) @(posedge clock);

      test_reset_settings();
      test_register_extremes();
      test_midstring_update();

      // Handshake profiles: none, sender idle, receiver stalling, both
      test_random_strings(260, 0, 0);
      test_random_strings(260, 60, 0);
      test_random_strings(260, 0, 60);
      test_random_strings(260, 26, 26);

      wait_until_quiet(EndCycles);
      if (pending_hashes.size() != 0) begin
         error_count++;
         $display("%0t: %0d predicted hashes never arrived", $time, pending_hashes.size());
      end

      $display("Sent %0d bytes in %0d strings under %0d register settings", requests_sent,
               strings_sent, settings_applied);
      $display("and four handshake profiles; checked %0d hashes, %0d errors.",
               hashes_checked, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
